@@ rtl/vh256_pkg.sv @@
// Shared types and constants for the 256-step heading block.
`timescale 1ns / 1ps
package vh256_pkg;

   // Quotient bits out of the divider: minor*256/major never exceeds 256.
   localparam int QUO_BITS = 9;
   localparam int CNT_BITS = 4;

   // Heading constants.
   localparam logic [7:0] QUAD_WEST  = 8'hC0;
   localparam logic [7:0] QUAD_FLIP  = 8'h40;
   localparam logic [7:0] ADJ_BIAS   = 8'h3F;
   localparam logic [7:0] SAME_POINT = 8'hFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MAG,
      ST_ORDER,
      ST_NORM,
      ST_DIV,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                done;
      logic [QUO_BITS-1:0] quotient;
   } div_result_type;

endpackage

@@ rtl/vh256_if.sv @@
// Request and response channel interfaces for the heading block.
`timescale 1ns / 1ps
interface vh256_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] source_x;
   logic signed [COORD_WIDTH-1:0] source_y;
   logic signed [COORD_WIDTH-1:0] target_x;
   logic signed [COORD_WIDTH-1:0] target_y;

   modport source (output valid, source_x, source_y, target_x, target_y, input ready);
   modport sink   (input valid, source_x, source_y, target_x, target_y, output ready);
endinterface

interface vh256_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] heading;

   modport source (output valid, heading, input ready);
   modport sink   (input valid, heading, output ready);
endinterface

@@ rtl/vh256_div.sv @@
// Restoring divider, one quotient bit per cycle, for a dividend not above the divisor.
`timescale 1ns / 1ps
module vh256_div #(
   parameter int WIDTH = 33
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [WIDTH-1:0]         dividend,
   input  logic [WIDTH-1:0]         divisor,
   output vh256_pkg::div_result_type result
);

   logic [WIDTH:0]                     rem_ff, rem_in;
   logic [WIDTH-1:0]                   divisor_ff, divisor_in;
   logic [vh256_pkg::QUO_BITS-1:0]     quo_ff, quo_in;
   logic [vh256_pkg::CNT_BITS-1:0]     count_ff, count_in;
   logic                               active_ff, active_in;
   logic                               done_ff, done_in;
   logic [WIDTH:0]                     trial;
   logic [WIDTH:0]                     kept;
   logic                               fits;

   // Trial subtract against the held divisor.
   always_comb begin
      fits  = rem_ff >= {1'b0, divisor_ff};
      trial = rem_ff - {1'b0, divisor_ff};
      kept  = fits ? trial : rem_ff;
   end

   always_comb begin
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = {1'b0, dividend};
         divisor_in = divisor;
         count_in   = vh256_pkg::CNT_BITS'(vh256_pkg::QUO_BITS);
         active_in  = 1'b1;
      end else if (active_ff) begin
         // Remainder stays below the divisor, so the doubled value fits.
         rem_in   = {kept[WIDTH-1:0], 1'b0};
         quo_in   = {quo_ff[vh256_pkg::QUO_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == vh256_pkg::CNT_BITS'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
      count_ff   <= count_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

@@ rtl/vector_heading_256_core.sv @@
// Top level of the 256-step heading block: sequencer, magnitude path and result register.
`timescale 1ns / 1ps
//
//  channel    direction  handshake               payload
//  req_chan   in         valid/ready             source_x, source_y, target_x, target_y
//  rsp_chan   out        valid/ready             heading (0 north, 63 east)
//
//  From acceptance to the response register a request passes the difference, magnitude,
//  order and normalize steps, the nine-step restoring divide and the final step; the
//  normalize step repeats once per shift while the major still needs shifting.
//  One request is in flight at a time; req_chan.ready is high only while idle.
//  A finished heading waits in the response register; a new request is taken meanwhile,
//  and the sequencer holds at the end of the next request until that register drains.
//  Reset is synchronous and clears the sequencer, divider control and response valid.
//
module vector_heading_256_core #(
   parameter int COORD_WIDTH = 32
) (
   input logic          clock,
   input logic          reset,
   vh256_req_if.sink    req_chan,
   vh256_rsp_if.source  rsp_chan
);

   // Magnitudes are exact differences: one bit wider than a coordinate.
   localparam int MAG_WIDTH = COORD_WIDTH + 1;

   vh256_pkg::state_type state_ff, state_in;

   // Captured request.
   logic [COORD_WIDTH-1:0] src_x_ff, src_y_ff, tgt_x_ff, tgt_y_ff;
   logic [COORD_WIDTH-1:0] src_x_in, src_y_in, tgt_x_in, tgt_y_in;

   // Signed differences, then magnitudes in major/minor.
   logic signed [MAG_WIDTH-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [MAG_WIDTH-1:0]        major_ff, minor_ff, major_in, minor_in;

   // Quadrant and special-case flags.
   logic west_ff, flip_ff, neg_ff, small_ff, zero_ff;
   logic west_in, flip_in, neg_in, small_in, zero_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] heading_ff, heading_in;

   // Sequencer outputs.
   logic req_ready;
   logic div_start;
   logic rsp_load;

   logic                      req_take;
   logic                      rsp_take;
   logic                      vert_major;
   logic                      major_wide;
   logic                      major_coarse;
   logic [7:0]                base;
   logic [7:0]                q8;
   logic [7:0]                heading_calc;
   vh256_pkg::div_result_type div_res;

   assign req_take = req_chan.valid && req_ready;
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;

   //--------------------------------------------------------------------------
   // Divider: minor*256/major, one quotient bit per cycle.
   //--------------------------------------------------------------------------
   vh256_div #(
      .WIDTH (MAG_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (minor_ff),
      .divisor  (major_ff),
      .result   (div_res)
   );

   //--------------------------------------------------------------------------
   // Next state.
   //--------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vh256_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = vh256_pkg::ST_DIFF;
            end
         end
         vh256_pkg::ST_DIFF:  state_in = vh256_pkg::ST_MAG;
         vh256_pkg::ST_MAG:   state_in = vh256_pkg::ST_ORDER;
         vh256_pkg::ST_ORDER: state_in = vh256_pkg::ST_NORM;
         vh256_pkg::ST_NORM: begin
            // Leave once the major fits in 8 bits, or at once for a wide minor.
            if (!(small_ff && major_wide)) begin
               state_in = vh256_pkg::ST_DIV;
            end
         end
         vh256_pkg::ST_DIV:   state_in = vh256_pkg::ST_WAIT;
         vh256_pkg::ST_WAIT: begin
            if (div_res.done) begin
               state_in = vh256_pkg::ST_DONE;
            end
         end
         vh256_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = vh256_pkg::ST_IDLE;
            end
         end
         default: state_in = vh256_pkg::ST_IDLE;
      endcase
   end

   //--------------------------------------------------------------------------
   // Sequencer outputs.
   //--------------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         vh256_pkg::ST_IDLE: req_ready = 1'b1;
         vh256_pkg::ST_DIV:  div_start = 1'b1;
         // Hold the result until the response register is free.
         vh256_pkg::ST_DONE: rsp_load  = !rsp_valid_ff || rsp_chan.ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   //--------------------------------------------------------------------------
   // Datapath.
   //--------------------------------------------------------------------------
   assign vert_major   = minor_ff >= major_ff;
   assign major_wide   = (major_ff >> 8) != '0;
   assign major_coarse = (major_ff >> 12) != '0;

   always_comb begin
      src_x_in = src_x_ff;
      src_y_in = src_y_ff;
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      west_in  = west_ff;
      flip_in  = flip_ff;
      neg_in   = neg_ff;
      small_in = small_ff;
      zero_in  = zero_ff;
      case (state_ff)
         vh256_pkg::ST_IDLE: begin
            if (req_take) begin
               src_x_in = req_chan.source_x;
               src_y_in = req_chan.source_y;
               tgt_x_in = req_chan.target_x;
               tgt_y_in = req_chan.target_y;
            end
         end
         vh256_pkg::ST_DIFF: begin
            // Exact differences; north is source_y - target_y since y grows south.
            dx_in = $signed({tgt_x_ff[COORD_WIDTH-1], tgt_x_ff})
                  - $signed({src_x_ff[COORD_WIDTH-1], src_x_ff});
            dy_in = $signed({src_y_ff[COORD_WIDTH-1], src_y_ff})
                  - $signed({tgt_y_ff[COORD_WIDTH-1], tgt_y_ff});
         end
         vh256_pkg::ST_MAG: begin
            // Hold |dx| in major and |dy| in minor until ordered.
            west_in  = dx_ff[MAG_WIDTH-1];
            flip_in  = dy_ff[MAG_WIDTH-1];
            major_in = dx_ff[MAG_WIDTH-1] ? MAG_WIDTH'(-dx_ff) : MAG_WIDTH'(dx_ff);
            minor_in = dy_ff[MAG_WIDTH-1] ? MAG_WIDTH'(-dy_ff) : MAG_WIDTH'(dy_ff);
         end
         vh256_pkg::ST_ORDER: begin
            // Ties go to the vertical axis.
            if (vert_major) begin
               major_in = minor_ff;
               minor_in = major_ff;
               small_in = (major_ff >> 8) == '0;
               zero_in  = minor_ff == '0;
            end else begin
               small_in = (minor_ff >> 8) == '0;
               zero_in  = major_ff == '0;
            end
            neg_in = !(west_ff ^ flip_ff) ^ vert_major;
         end
         vh256_pkg::ST_NORM: begin
            // Shift by four while that still leaves the major at 8 bits or more, else by one.
            if (small_ff && major_wide) begin
               if (major_coarse) begin
                  major_in = major_ff >> 4;
                  minor_in = minor_ff >> 4;
               end else begin
                  major_in = major_ff >> 1;
                  minor_in = minor_ff >> 1;
               end
            end
         end
         default: begin
            zero_in = zero_ff;
         end
      endcase
   end

   //--------------------------------------------------------------------------
   // Heading: quadrant base plus or minus the scaled quotient.
   //--------------------------------------------------------------------------
   always_comb begin
      base = (west_ff ? vh256_pkg::QUAD_WEST : 8'h00)
           ^ (flip_ff ? vh256_pkg::QUAD_FLIP : 8'h00);
      if (zero_ff) begin
         q8 = vh256_pkg::SAME_POINT;
      end else begin
         q8 = {{(11 - vh256_pkg::QUO_BITS){1'b0}},
               div_res.quotient[vh256_pkg::QUO_BITS-1:3]};
      end
      if (neg_ff) begin
         heading_calc = base + vh256_pkg::ADJ_BIAS - q8;
      end else begin
         heading_calc = base + q8;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      heading_in   = heading_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         heading_in   = heading_calc;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      src_x_ff   <= src_x_in;
      src_y_ff   <= src_y_in;
      tgt_x_ff   <= tgt_x_in;
      tgt_y_ff   <= tgt_y_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      major_ff   <= major_in;
      minor_ff   <= minor_in;
      west_ff    <= west_in;
      flip_ff    <= flip_in;
      neg_ff     <= neg_in;
      small_ff   <= small_in;
      zero_ff    <= zero_in;
      heading_ff <= heading_in;
      if (reset) begin
         state_ff     <= vh256_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.heading = heading_ff;

   //--------------------------------------------------------------------------
   // Checks.
   //--------------------------------------------------------------------------
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == vh256_pkg::ST_DIFF)
      else $error("accepted request did not start the sequence");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == vh256_pkg::ST_DONE)
      else $error("response raised outside the final step");

   a_norm_order : assert property (@(posedge clock) disable iff (reset)
      state_ff == vh256_pkg::ST_NORM |-> major_ff >= minor_ff)
      else $error("minor axis exceeds major axis while normalizing");

   a_div_done_wait : assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == vh256_pkg::ST_WAIT)
      else $error("divider finished while sequencer was not waiting");

endmodule
